@@ rtl/hbs_pkg.sv @@
// Shared types and constants for the handle bitmap set.
// Request codes, beat field widths and the controller/datapath interface.
// No dependencies.
`default_nettype none

package hbs_pkg;

  localparam int HANDLE_W   = 10;
  localparam int TOTAL_W    = 11;
  localparam int REQ_W      = 3;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [REQ_W-1:0] {
    REQ_SET     = 3'd0,
    REQ_CLEAR   = 3'd1,
    REQ_TEST    = 3'd2,
    REQ_CLR_ALL = 3'd3,
    REQ_REWIND  = 3'd4,
    REQ_NEXT    = 3'd5
  } req_t;

  typedef struct packed {
    logic cap;
    logic rd;
    logic exec;
    logic scan_rd;
    logic scan_chk;
    logic load;
  } hbs_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic hit;
  } hbs_sts_t;

endpackage

`default_nettype wire

@@ rtl/hbs_ctrl.sv @@
// Controller state machine for the handle bitmap set.
// Sequences read, execute, word scan and result load; depends on hbs_pkg.
`default_nettype none

module hbs_ctrl
  import hbs_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  wire logic     out_tready,
  input  wire hbs_sts_t sts,
  output hbs_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   can_load;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign can_load   = !out_valid_r || out_tready;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.need_scan ? S_SCAN_RD : S_FIN;
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_nxt   = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        cmd.scan_chk = 1'b1;
        state_nxt    = sts.hit ? S_FIN : S_SCAN_RD;
      end
      S_FIN: begin
        if (can_load) begin
          cmd.load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/hbs_dp.sv @@
// Datapath for the handle bitmap set: bitmap memory with word valid bits,
// member count, highest member, iterator cursor and result registers.
// Depends on hbs_pkg; driven by hbs_ctrl commands.
`default_nettype none

module hbs_dp
  import hbs_pkg::*;
#(
  parameter int NUM_HANDLES = 1024,
  parameter int WORD_BITS   = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire hbs_cmd_t              cmd,
  output hbs_sts_t                   sts,
  input  wire logic [REQ_W-1:0]      in_req,
  input  wire logic [HANDLE_W-1:0]   in_handle,
  output logic [OUT_DATA_W-1:0]      out_data
);

  localparam int NUM_WORDS = (NUM_HANDLES + WORD_BITS - 1) / WORD_BITS;
  localparam int WIW       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BW        = $clog2(WORD_BITS);
  localparam int AW        = ($clog2(NUM_HANDLES) > HANDLE_W) ? $clog2(NUM_HANDLES) : HANDLE_W;
  localparam int CW        = $clog2(NUM_HANDLES + 1);
  localparam logic [AW:0] NLIM = (AW + 1)'(NUM_HANDLES);

  function automatic logic [BW-1:0] msb_idx(input logic [WORD_BITS-1:0] w);
    logic [BW-1:0] r;
    r = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (w[i]) r = BW'(i);
    end
    return r;
  endfunction

  function automatic logic [BW-1:0] lsb_idx(input logic [WORD_BITS-1:0] w);
    logic [BW-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) r = BW'(i);
    end
    return r;
  endfunction

  function automatic logic [AW-1:0] word_base(input logic [WIW-1:0] idx);
    return AW'(idx) << BW;
  endfunction

  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] wvalid_r;
  logic [WORD_BITS-1:0] rdata_r;
  logic                 rvalid_r;

  logic [REQ_W-1:0] req_r;
  logic [AW-1:0]    h_r;
  logic [AW:0]      cursor_r, cursor_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [AW-1:0]    top_r, top_nxt;
  logic             present_r, present_nxt;
  logic [WIW-1:0]   scan_idx_r, scan_idx_nxt;
  logic             scan_up_r, scan_up_nxt;
  logic             res_member_r, res_member_nxt;
  logic [AW-1:0]    res_next_r, res_next_nxt;
  logic             res_nv_r, res_nv_nxt;

  logic                 o_member_r;
  logic [TOTAL_W-1:0]   o_total_r;
  logic [HANDLE_W-1:0]  o_top_r;
  logic                 o_top_valid_r;
  logic [HANDLE_W-1:0]  o_next_r;
  logic                 o_next_valid_r;

  logic [WORD_BITS-1:0] word;
  logic [BW-1:0]        bp, cbp;
  logic [WIW-1:0]       hw, cw, raddr;
  logic                 in_rng, cur_bit;
  logic [WORD_BITS-1:0] bmask, lo_word, hi_word;
  logic                 we, wvalid_clr;
  logic [WORD_BITS-1:0] wdata;
  logic [AW-1:0]        found_h;

  assign word    = rvalid_r ? rdata_r : '0;
  assign bp      = h_r[BW-1:0];
  assign cbp     = cursor_r[BW-1:0];
  assign hw      = WIW'(h_r >> BW);
  assign cw      = WIW'(cursor_r >> BW);
  assign in_rng  = ({1'b0, h_r} < NLIM);
  assign cur_bit = in_rng && word[bp];
  assign bmask   = WORD_BITS'(1) << bp;
  assign lo_word = (word & ~bmask) & ~({WORD_BITS{1'b1}} << bp);
  assign hi_word = word & ({WORD_BITS{1'b1}} << cbp);
  assign raddr   = cmd.scan_rd ? scan_idx_r : ((req_r == REQ_NEXT) ? cw : hw);

  always_comb begin
    cursor_nxt     = cursor_r;
    count_nxt      = count_r;
    top_nxt        = top_r;
    present_nxt    = present_r;
    scan_idx_nxt   = scan_idx_r;
    scan_up_nxt    = scan_up_r;
    res_member_nxt = res_member_r;
    res_next_nxt   = res_next_r;
    res_nv_nxt     = res_nv_r;
    we             = 1'b0;
    wvalid_clr     = 1'b0;
    wdata          = word;
    found_h        = '0;
    sts            = '0;

    if (cmd.cap) begin
      res_member_nxt = 1'b0;
      res_next_nxt   = '0;
      res_nv_nxt     = 1'b0;
    end

    if (cmd.exec) begin
      case (req_r)
        REQ_SET: begin
          res_member_nxt = in_rng;
          if (in_rng && !cur_bit) begin
            we        = 1'b1;
            wdata     = word | bmask;
            count_nxt = count_r + CW'(1);
            if (!present_r || h_r > top_r) begin
              top_nxt     = h_r;
              present_nxt = 1'b1;
            end
          end
        end
        REQ_CLEAR: begin
          if (cur_bit) begin
            we        = 1'b1;
            wdata     = word & ~bmask;
            count_nxt = count_r - CW'(1);
            if (present_r && h_r == top_r) begin
              if (count_r == CW'(1)) begin
                present_nxt = 1'b0;
                top_nxt     = '0;
              end else if (lo_word != '0) begin
                top_nxt = word_base(hw) + AW'(msb_idx(lo_word));
              end else begin
                scan_idx_nxt  = hw - WIW'(1);
                scan_up_nxt   = 1'b0;
                sts.need_scan = 1'b1;
              end
            end
          end
        end
        REQ_TEST: begin
          res_member_nxt = cur_bit;
        end
        REQ_CLR_ALL: begin
          wvalid_clr  = 1'b1;
          count_nxt   = '0;
          top_nxt     = '0;
          present_nxt = 1'b0;
        end
        REQ_REWIND: begin
          cursor_nxt = '0;
        end
        REQ_NEXT: begin
          if (present_r && cursor_r <= {1'b0, top_r}) begin
            if (hi_word != '0) begin
              found_h      = word_base(cw) + AW'(lsb_idx(hi_word));
              res_next_nxt = found_h;
              res_nv_nxt   = 1'b1;
              cursor_nxt   = {1'b0, found_h} + (AW + 1)'(1);
            end else begin
              scan_idx_nxt  = cw + WIW'(1);
              scan_up_nxt   = 1'b1;
              sts.need_scan = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd.scan_chk) begin
      if (word != '0) begin
        sts.hit = 1'b1;
        if (scan_up_r) begin
          found_h      = word_base(scan_idx_r) + AW'(lsb_idx(word));
          res_next_nxt = found_h;
          res_nv_nxt   = 1'b1;
          cursor_nxt   = {1'b0, found_h} + (AW + 1)'(1);
        end else begin
          top_nxt = word_base(scan_idx_r) + AW'(msb_idx(word));
        end
      end else begin
        scan_idx_nxt = scan_up_r ? scan_idx_r + WIW'(1) : scan_idx_r - WIW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[hw] <= wdata;
    end
    if (cmd.rd || cmd.scan_rd) begin
      rdata_r  <= mem[raddr];
      rvalid_r <= wvalid_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wvalid_r  <= '0;
      cursor_r  <= '0;
      count_r   <= '0;
      top_r     <= '0;
      present_r <= 1'b0;
    end else begin
      if (wvalid_clr) begin
        wvalid_r <= '0;
      end else if (we) begin
        wvalid_r[hw] <= 1'b1;
      end
      cursor_r  <= cursor_nxt;
      count_r   <= count_nxt;
      top_r     <= top_nxt;
      present_r <= present_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req_r <= in_req;
      h_r   <= AW'(in_handle);
    end
    scan_idx_r   <= scan_idx_nxt;
    scan_up_r    <= scan_up_nxt;
    res_member_r <= res_member_nxt;
    res_next_r   <= res_next_nxt;
    res_nv_r     <= res_nv_nxt;
    if (cmd.load) begin
      o_member_r     <= res_member_r;
      o_total_r      <= TOTAL_W'(count_r);
      o_top_r        <= HANDLE_W'(top_r);
      o_top_valid_r  <= present_r;
      o_next_r       <= HANDLE_W'(res_next_r);
      o_next_valid_r <= res_nv_r;
    end
  end

  assign out_data = {6'd0, o_next_valid_r, o_next_r, o_top_valid_r, o_top_r,
                     o_total_r, o_member_r};

endmodule

`default_nettype wire

@@ rtl/handle_bitmap_set_with_max_and_iterator.sv @@
// Sequencing: set, clear, test, clear all, rewind and next member without a scan pass
// through the idle (capture), read, execute and final (load) states, and the load waits
// while a result is stalled; each bitmap word a scan visits adds one memory read and one
// check, up to NUM_WORDS - 1 words. Throughput: one request at a time; the controller's
// read-execute-scan loop over the single-port bitmap memory sets the rate. A new beat is
// taken while a result waits. Reset: synchronous, active low; per-word valid bits empty the bitmap at once.
`default_nettype none

module handle_bitmap_set_with_max_and_iterator
  import hbs_pkg::*;
#(
  parameter int NUM_HANDLES = 1024,
  parameter int WORD_BITS   = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_DATA_W-1:0]   in_tdata,   // handle[9:0], zero fill
  input  wire logic [REQ_W-1:0]       in_tuser,   // req_type[2:0]
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_DATA_W-1:0]       out_tdata   // is_member, member_total[11], top_handle[10],
                                                  // top_valid, next_handle[10], next_valid, zero fill
);

  hbs_cmd_t cmd;
  hbs_sts_t sts;

  hbs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  hbs_dp #(
    .NUM_HANDLES (NUM_HANDLES),
    .WORD_BITS   (WORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_req    (in_tuser),
    .in_handle (in_tdata[HANDLE_W-1:0]),
    .out_data  (out_tdata)
  );

endmodule

`default_nettype wire

@@ rtl/hbs_chk.sv @@
// Port-level checker for the handle bitmap set, bound to the top level.
// Uses only the top-level ports; no package dependency.
`default_nettype none

module hbs_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [15:0] in_tdata,
  input wire logic [2:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Output beat changed while stalled.");

  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[22] |-> out_tdata[21:12] == 10'd0)
    else $error("Top handle nonzero with empty set.");

  a_count_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[11:1] == 11'd0) == !out_tdata[22]))
    else $error("Member total disagrees with top valid.");

  a_next_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[33] |-> out_tdata[22] && (out_tdata[32:23] <= out_tdata[21:12]))
    else $error("Next member above the highest member.");

  a_next_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[33] |-> out_tdata[32:23] == 10'd0)
    else $error("Next handle nonzero without a hit.");

endmodule

bind handle_bitmap_set_with_max_and_iterator hbs_chk u_chk (.*);

`default_nettype wire
